### hdl/gbt_pkg.sv
// ----------------------------------------------------------------------------
// gbt_pkg
// Shared sizes and constants of the graph traversal unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gbt_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;

    // field widths
    localparam int VW      = 6;   // vertex number
    localparam int CFG_VCW = 7;   // vertex_count register
    localparam int CFG_W   = 7;   // config data

    // derived sizes
    localparam int QAW   = $clog2(MAX_VERTICES);                  // vertex index
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);              // vertex count
    localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1; // edge index
    localparam int CW    = EAW + 1;                               // edge cursor

    localparam logic [CW-1:0] NO_EDGE = CW'(MAX_EDGES);

    // config register indexes
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_WALK_MODE    = 1'b1;

endpackage

`default_nettype wire

### hdl/graph_bfs_dfs_traversal_unit.sv
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_unit
// Loads a directed graph one edge per transaction, then walks it breadth- or
// depth-first and streams out every vertex once in visit order.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one edge per transaction; s_tuser = edge present, s_tlast ends
//   loading and starts the walk. Edges with an endpoint at or past
//   vertex_count, or arriving when the edge store is full, are dropped.
//   Each edge is stored by a tail RAM read, then a link update.
//   m_ channel: one vertex per transaction, m_tlast on the final vertex.
//   The walk is run by one sequencer over the shared edge RAMs; s_tready
//   stays low until the walk is done.
//   The last vertex leaves one result late, so the walk holds one vertex
//   back until it knows which is final.
//   A stall on m_tready stalls the sequencer at the next emission; nothing
//   is lost. After the walk the graph and visited map are cleared.
//   Reset (aresetn low, synchronous) empties the graph and sets
//   vertex_count 64, breadth-first. Config writes are taken at any cycle
//   with cfg_we high and are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_bfs_dfs_traversal_unit (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // configuration
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [gbt_pkg::CFG_W-1:0] cfg_data,
    // edge input
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [15:0]               s_tdata,   // [5:0] from_vertex, [11:6] to_vertex
    input  wire logic                      s_tuser,   // edge_present
    input  wire logic                      s_tlast,   // last_item
    // vertex output
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [7:0]                     m_tdata,   // [5:0] visited_vertex
    output logic                           m_tlast    // last_vertex
);

    import gbt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LINK   = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_QPOP   = 4'd3;
    localparam logic [3:0] S_QWAIT  = 4'd4;
    localparam logic [3:0] S_EMIT   = 4'd5;
    localparam logic [3:0] S_HEADRD = 4'd6;
    localparam logic [3:0] S_HEAD   = 4'd7;
    localparam logic [3:0] S_EDGE   = 4'd8;
    localparam logic [3:0] S_EDGE2  = 4'd9;
    localparam logic [3:0] S_DTOP   = 4'd10;
    localparam logic [3:0] S_DE2    = 4'd11;
    localparam logic [3:0] S_DPOP   = 4'd12;
    localparam logic [3:0] S_FLUSH  = 4'd13;

    // config
    logic [CFG_VCW-1:0] vcount_reg;
    logic               mode_reg;

    // control
    logic [3:0]              state_reg, state_next;
    logic [3:0]              ret_reg, ret_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [VW-1:0]           from_reg, from_next;
    logic                    last_reg, last_next;
    logic [CW-1:0]           fill_reg, fill_next;
    logic [MAX_VERTICES-1:0] hv_reg, hv_next;
    logic [MAX_VERTICES-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0]        s_reg, s_next;
    logic [CNT_W-1:0]        rd_reg, rd_next;
    logic [CNT_W-1:0]        wr_reg, wr_next;
    logic [CNT_W-1:0]        sp_reg, sp_next;
    logic [VW-1:0]           v_reg, v_next;
    logic [CW-1:0]           cur_reg, cur_next;
    logic [VW-1:0]           pend_reg, pend_next;
    logic                    pend_vld_reg, pend_vld_next;
    logic                    mv_reg, mv_next;
    logic [VW-1:0]           mdata_reg, mdata_next;
    logic                    mlast_reg, mlast_next;

    // RAM ports
    logic           tail_we, head_we, tgt_we, link_we, q_we, stk_we;
    logic [QAW-1:0] tail_raddr, head_raddr, q_waddr, q_raddr, stk_waddr, stk_raddr;
    logic [EAW-1:0] link_waddr;
    logic [CW-1:0]  link_wdata;
    logic [VW-1:0]  q_wdata;
    logic [CW-1:0]  stk_wdata;
    logic [EAW-1:0] tail_rdata, head_rdata;
    logic [VW-1:0]  tgt_rdata, q_rdata;
    logic [CW-1:0]  link_rdata, stk_rdata;

    logic [VW-1:0]      in_from, in_to;
    logic               accept, edge_ok, slot_free, t_new;
    logic [CNT_W-1:0]   n_in, t_ext;

    assign in_from   = s_tdata[5:0];
    assign in_to     = s_tdata[11:6];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !mv_reg || m_tready;
    assign n_in      = (vcount_reg > CFG_VCW'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                             : CNT_W'(vcount_reg);
    assign edge_ok   = s_tuser && (CNT_W'(in_from) < n_in) && (CNT_W'(in_to) < n_in)
                       && (fill_reg < CW'(MAX_EDGES));
    assign t_ext     = CNT_W'(tgt_rdata);
    assign t_new     = (t_ext < n_reg) && !seen_reg[tgt_rdata[QAW-1:0]];

    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'b00, mdata_reg};
    assign m_tlast  = mlast_reg;

    // RAM addressing
    assign tail_we    = (state_reg == S_LINK);
    assign head_we    = (state_reg == S_LINK) && !hv_reg[from_reg[QAW-1:0]];
    assign tail_raddr = in_from[QAW-1:0];
    assign head_raddr = v_reg[QAW-1:0];
    assign tgt_we     = accept && edge_ok;
    assign link_we    = tgt_we || ((state_reg == S_LINK) && hv_reg[from_reg[QAW-1:0]]);
    assign link_waddr = (state_reg == S_LINK) ? tail_rdata : fill_reg[EAW-1:0];
    assign link_wdata = (state_reg == S_LINK) ? fill_reg : NO_EDGE;
    assign q_we       = ((state_reg == S_SCAN) && !mode_reg && (s_reg < n_reg)
                         && !seen_reg[s_reg[QAW-1:0]])
                        || ((state_reg == S_EDGE2) && t_new);
    assign q_waddr    = wr_reg[QAW-1:0];
    assign q_wdata    = (state_reg == S_SCAN) ? s_reg[VW-1:0] : tgt_rdata;
    assign q_raddr    = rd_reg[QAW-1:0];
    assign stk_we     = (state_reg == S_DE2) && t_new;
    assign stk_waddr  = QAW'(sp_reg - CNT_W'(1));
    assign stk_wdata  = link_rdata;
    assign stk_raddr  = QAW'(sp_reg - CNT_W'(2));

    gbt_ram #(.DEPTH(MAX_VERTICES), .WIDTH(EAW)) u_tail (
        .aclk(aclk), .we(tail_we), .waddr(from_reg[QAW-1:0]),
        .wdata(fill_reg[EAW-1:0]), .raddr(tail_raddr), .rdata(tail_rdata));

    gbt_ram #(.DEPTH(MAX_VERTICES), .WIDTH(EAW)) u_head (
        .aclk(aclk), .we(head_we), .waddr(from_reg[QAW-1:0]),
        .wdata(fill_reg[EAW-1:0]), .raddr(head_raddr), .rdata(head_rdata));

    gbt_ram #(.DEPTH(MAX_EDGES), .WIDTH(VW)) u_target (
        .aclk(aclk), .we(tgt_we), .waddr(fill_reg[EAW-1:0]),
        .wdata(in_to), .raddr(cur_reg[EAW-1:0]), .rdata(tgt_rdata));

    gbt_ram #(.DEPTH(MAX_EDGES), .WIDTH(CW)) u_link (
        .aclk(aclk), .we(link_we), .waddr(link_waddr),
        .wdata(link_wdata), .raddr(cur_reg[EAW-1:0]), .rdata(link_rdata));

    gbt_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_queue (
        .aclk(aclk), .we(q_we), .waddr(q_waddr),
        .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata));

    gbt_ram #(.DEPTH(MAX_VERTICES), .WIDTH(CW)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr),
        .wdata(stk_wdata), .raddr(stk_raddr), .rdata(stk_rdata));

    // sequencer
    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        n_next        = n_reg;
        from_next     = from_reg;
        last_next     = last_reg;
        fill_next     = fill_reg;
        hv_next       = hv_reg;
        seen_next     = seen_reg;
        s_next        = s_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        sp_next       = sp_reg;
        v_next        = v_reg;
        cur_next      = cur_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        mv_next       = mv_reg && !m_tready;
        mdata_next    = mdata_reg;
        mlast_next    = mlast_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    n_next    = n_in;
                    from_next = in_from;
                    last_next = s_tlast;
                    s_next    = '0;
                    rd_next   = '0;
                    wr_next   = '0;
                    sp_next   = '0;
                    if (edge_ok) begin
                        state_next = S_LINK;
                    end else if (s_tlast) begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_LINK: begin
                hv_next[from_reg[QAW-1:0]] = 1'b1;
                fill_next  = fill_reg + CW'(1);
                state_next = last_reg ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (s_reg >= n_reg) begin
                    state_next = S_FLUSH;
                end else if (seen_reg[s_reg[QAW-1:0]]) begin
                    s_next = s_reg + CNT_W'(1);
                end else begin
                    seen_next[s_reg[QAW-1:0]] = 1'b1;
                    if (mode_reg) begin
                        v_next     = s_reg[VW-1:0];
                        sp_next    = CNT_W'(1);
                        ret_next   = S_HEADRD;
                        state_next = S_EMIT;
                    end else begin
                        wr_next    = wr_reg + CNT_W'(1);
                        state_next = S_QPOP;
                    end
                end
            end
            S_QPOP: begin
                if (rd_reg < wr_reg) begin
                    rd_next    = rd_reg + CNT_W'(1);
                    state_next = S_QWAIT;
                end else begin
                    s_next     = s_reg + CNT_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_QWAIT: begin
                v_next     = q_rdata;
                ret_next   = S_HEADRD;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // hand the held vertex out, hold the new one
                if (!pend_vld_reg || slot_free) begin
                    if (pend_vld_reg) begin
                        mv_next    = 1'b1;
                        mdata_next = pend_reg;
                        mlast_next = 1'b0;
                    end
                    pend_next     = v_reg;
                    pend_vld_next = 1'b1;
                    state_next    = ret_reg;
                end
            end
            S_HEADRD: begin
                state_next = S_HEAD;
            end
            S_HEAD: begin
                cur_next   = hv_reg[v_reg[QAW-1:0]] ? {1'b0, head_rdata} : NO_EDGE;
                state_next = mode_reg ? S_DTOP : S_EDGE;
            end
            S_EDGE: begin
                state_next = (cur_reg >= NO_EDGE) ? S_QPOP : S_EDGE2;
            end
            S_EDGE2: begin
                cur_next = link_rdata;
                if (t_new) begin
                    seen_next[tgt_rdata[QAW-1:0]] = 1'b1;
                    wr_next = wr_reg + CNT_W'(1);
                end
                state_next = S_EDGE;
            end
            S_DTOP: begin
                if (sp_reg == '0) begin
                    s_next     = s_reg + CNT_W'(1);
                    state_next = S_SCAN;
                end else if (cur_reg >= NO_EDGE) begin
                    // frame done: pop, restore parent cursor
                    sp_next = sp_reg - CNT_W'(1);
                    if (sp_reg > CNT_W'(1)) begin
                        state_next = S_DPOP;
                    end
                end else begin
                    state_next = S_DE2;
                end
            end
            S_DE2: begin
                cur_next = link_rdata;
                if (t_new) begin
                    seen_next[tgt_rdata[QAW-1:0]] = 1'b1;
                    sp_next    = sp_reg + CNT_W'(1);
                    v_next     = tgt_rdata;
                    ret_next   = S_HEADRD;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_DTOP;
                end
            end
            S_DPOP: begin
                cur_next   = stk_rdata;
                state_next = S_DTOP;
            end
            S_FLUSH: begin
                if (!pend_vld_reg || slot_free) begin
                    if (pend_vld_reg) begin
                        mv_next    = 1'b1;
                        mdata_next = pend_reg;
                        mlast_next = 1'b1;
                    end
                    pend_vld_next = 1'b0;
                    hv_next       = '0;
                    seen_next     = '0;
                    fill_next     = '0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= CFG_VCW'(64);
            mode_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT: vcount_reg <= cfg_data[CFG_VCW-1:0];
                CFG_WALK_MODE:    mode_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            hv_reg       <= '0;
            seen_reg     <= '0;
            pend_vld_reg <= 1'b0;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            hv_reg       <= hv_next;
            seen_reg     <= seen_next;
            pend_vld_reg <= pend_vld_next;
            mv_reg       <= mv_next;
        end
    end

    // payload and counters
    always_ff @(posedge aclk) begin
        ret_reg   <= ret_next;
        n_reg     <= n_next;
        from_reg  <= from_next;
        last_reg  <= last_next;
        s_reg     <= s_next;
        rd_reg    <= rd_next;
        wr_reg    <= wr_next;
        sp_reg    <= sp_next;
        v_reg     <= v_next;
        cur_reg   <= cur_next;
        pend_reg  <= pend_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

endmodule

`default_nettype wire

### hdl/gbt_ram.sv
// ----------------------------------------------------------------------------
// gbt_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### bench/graph_bfs_dfs_traversal_unit_test.sv
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_unit_test
// Self-checking bench for the graph traversal unit: loads edge lists over the
// input stream, predicts the breadth- or depth-first visit order and compares
// every output transaction against it, with random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_bfs_dfs_traversal_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gbt_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_VERTEX_COUNT;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic m_tlast;

    graph_bfs_dfs_traversal_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic          final_flag;
    } visit_t;

    // predicted graph state
    int unsigned adj_head[MAX_VERTICES];
    int unsigned adj_tail[MAX_VERTICES];
    logic [VW-1:0] edge_dst[MAX_EDGES];
    int unsigned edge_next[MAX_EDGES];
    int unsigned edges_held;
    bit visited[MAX_VERTICES];
    int unsigned num_vertices = 64;
    bit depth_first = 1'b0;

    visit_t expected_visits[$];
    int errors = 0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;

    function automatic void clear_graph();
        for (int v = 0; v < MAX_VERTICES; v++) begin
            adj_head[v] = MAX_EDGES;
            adj_tail[v] = MAX_EDGES;
            visited[v] = 1'b0;
        end
        edges_held = 0;
    endfunction

    function automatic void store_edge(int unsigned src, int unsigned dst, int unsigned n);
        int unsigned e;
        if (src >= n || dst >= n || edges_held >= MAX_EDGES) return;
        e = edges_held++;
        edge_dst[e] = dst[VW-1:0];
        edge_next[e] = MAX_EDGES;
        if (adj_head[src] == MAX_EDGES) adj_head[src] = e;
        else edge_next[adj_tail[src]] = e;
        adj_tail[src] = e;
    endfunction

    // walk the stored graph and queue the visit order
    function automatic void predict_walk(int unsigned n);
        int unsigned order[$];
        int unsigned fifo[$];
        int unsigned stk_v[$];
        int unsigned stk_c[$];
        int unsigned v, c, t, e;
        visit_t item;
        for (int unsigned s = 0; s < n; s++) begin
            if (visited[s]) continue;
            visited[s] = 1'b1;
            if (!depth_first) begin
                fifo.insert(fifo.size(), s);
                while (fifo.size() > 0) begin
                    v = fifo.pop_front();
                    order.insert(order.size(), v);
                    for (e = adj_head[v]; e < MAX_EDGES; e = edge_next[e]) begin
                        t = edge_dst[e];
                        if (t < n && !visited[t]) begin
                            visited[t] = 1'b1;
                            fifo.insert(fifo.size(), t);
                        end
                    end
                end
            end else begin
                order.insert(order.size(), s);
                stk_v.insert(stk_v.size(), s);
                stk_c.insert(stk_c.size(), adj_head[s]);
                while (stk_c.size() > 0) begin
                    c = stk_c[$];
                    if (c >= MAX_EDGES) begin
                        void'(stk_c.pop_back());
                        void'(stk_v.pop_back());
                        continue;
                    end
                    t = edge_dst[c];
                    stk_c[stk_c.size()-1] = edge_next[c];
                    if (t < n && !visited[t] && stk_c.size() < MAX_VERTICES) begin
                        visited[t] = 1'b1;
                        order.insert(order.size(), t);
                        stk_v.insert(stk_v.size(), t);
                        stk_c.insert(stk_c.size(), adj_head[t]);
                    end
                end
            end
        end
        foreach (order[k]) begin
            item.vertex = order[k][VW-1:0];
            item.final_flag = (k == order.size() - 1);
            expected_visits.insert(expected_visits.size(), item);
        end
        clear_graph();
    endfunction

    // send one item; prediction follows acceptance
    task automatic send_edge(int unsigned src, int unsigned dst, bit has_edge, bit ends);
        int unsigned n;
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, dst[5:0], src[5:0]};
        s_tuser <= has_edge;
        s_tlast <= ends;
        do @(posedge aclk); while (!s_tready);
        n = (num_vertices > MAX_VERTICES) ? MAX_VERTICES : num_vertices;
        if (has_edge) store_edge(src, dst, n);
        if (ends) predict_walk(n);
        // drop valid after the final item so the walk does not take it twice
        if (ends) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic idx, int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_VERTEX_COUNT) num_vertices = value & 7'h7f;
        else depth_first = value[0];
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_visits.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_graph(int unsigned n_edges, int unsigned range);
        repeat (n_edges)
            send_edge($urandom_range(0, range), $urandom_range(0, range),
                      $urandom_range(0, 7) != 0, 1'b0);
        send_edge($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1), 1'b1);
    endtask

    // extremes, both modes, dropped endpoints, empty graph
    task automatic test_directed();
        write_reg(CFG_VERTEX_COUNT, 4);
        write_reg(CFG_WALK_MODE, 0);
        send_edge(0, 2, 1, 0);
        send_edge(0, 1, 1, 0);
        send_edge(2, 3, 1, 0);
        send_edge(1, 3, 1, 0);
        send_edge(63, 63, 1, 0);
        send_edge(3, 5, 1, 0);
        send_edge(0, 0, 0, 1);
        wait_drained();
        write_reg(CFG_WALK_MODE, 1);
        send_edge(0, 2, 1, 0);
        send_edge(2, 1, 1, 0);
        send_edge(1, 0, 1, 0);
        send_edge(3, 3, 1, 1);
        wait_drained();
        write_reg(CFG_VERTEX_COUNT, 1);
        send_edge(0, 0, 1, 1);
        wait_drained();
        write_reg(CFG_VERTEX_COUNT, 0);
        send_edge(0, 0, 1, 0);
        send_edge(0, 0, 0, 1);
        wait_drained();
        write_reg(CFG_VERTEX_COUNT, 64);
        send_edge(63, 0, 1, 0);
        send_edge(42, 21, 1, 1);
        wait_drained();
    endtask

    // more edges than the store holds
    task automatic test_store_full();
        write_reg(CFG_VERTEX_COUNT, 64);
        write_reg(CFG_WALK_MODE, 1);
        repeat (MAX_EDGES + 2)
            send_edge($urandom_range(0, 63), $urandom_range(0, 63), 1'b1, 1'b0);
        send_edge($urandom_range(0, 63), $urandom_range(0, 63), 1'b1, 1'b1);
        wait_drained();
    endtask

    // long receiver hold-off while the sender keeps offering items
    task automatic test_backpressure();
        write_reg(CFG_WALK_MODE, 0);
        write_reg(CFG_VERTEX_COUNT, 20);
        hold_off = 1'b1;
        random_graph(10, 19);
        send_edge(1, 2, 1, 0);
        send_edge(2, 3, 1, 1);
        hold_off = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        int unsigned n;
        for (int g = 0; g < 4; g++) begin
            n = (g % 5 == 0) ? $urandom_range(40, 64) : $urandom_range(2, 16);
            write_reg(CFG_VERTEX_COUNT, (g == 3) ? 127 : n);
            write_reg(CFG_WALK_MODE, $urandom_range(0, 1));
            random_graph($urandom_range(3, 8), (g % 4 == 1) ? 63 : n - 1);
            wait_drained();
        end
    endtask

    // receiver readiness
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                stall = 0;
                while (stall < 300) begin
                    @(posedge aclk);
                    stall++;
                end
                m_tready <= 1'b1;
                do @(posedge aclk); while (hold_off);
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        visit_t exp_v;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_visits.size() == 0) begin
                $error("unexpected vertex %0d", m_tdata[VW-1:0]);
                errors++;
            end else begin
                exp_v = expected_visits.pop_front();
                if (m_tdata[VW-1:0] !== exp_v.vertex) begin
                    $error("visited_vertex: expected %0d, got %0d", exp_v.vertex,
                           m_tdata[VW-1:0]);
                    errors++;
                end
                if (m_tlast !== exp_v.final_flag) begin
                    $error("last_vertex: expected %0b, got %0b", exp_v.final_flag, m_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("graph_bfs_dfs_traversal_unit regression: fail");
            $finish;
        end
    end

    initial begin
        clear_graph();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_store_full();
        test_backpressure();
        test_random();
        wait_drained();
        if (expected_visits.size() != 0) errors++;
        if (errors == 0) begin
            $display("graph_bfs_dfs_traversal_unit regression: pass");
        end else begin
            $display("graph_bfs_dfs_traversal_unit regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
